[sv/sab_pkg.sv]
package sab_pkg;

  // Capacity and alphabet
  localparam int MAX_STATES    = 2048;
  localparam int ALPHABET_SIZE = 26;

  // Derived widths
  localparam int SW          = $clog2(MAX_STATES);
  localparam int SYM_W       = 5;
  localparam int TRANS_DEPTH = MAX_STATES * ALPHABET_SIZE;
  localparam int TA_W        = $clog2(TRANS_DEPTH);

  // Stream widths
  localparam int IN_W   = 8;
  localparam int RES_W  = 5 * SW + 2;
  localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

  // Root state index
  localparam logic [SW-1:0] ROOT = SW'(1);

  // Flat address of one transition entry: state * alphabet + symbol
  function automatic logic [TA_W-1:0] trans_addr(input logic [SW-1:0] s,
                                                 input logic [SYM_W-1:0] c);
    return TA_W'(s) * TA_W'(ALPHABET_SIZE) + TA_W'(c);
  endfunction

endpackage

[sv/sab_ram.sv]
module sab_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/suffix_automaton_builder.sv]
// Online suffix automaton builder.
// Slave stream (s_*): one symbol per transaction, 0..25. Symbols out of range
// are ignored and still produce a result: state count as it was, every other
// field zero.
// Master stream (m_*): one result per symbol, held in an output register.
// A new symbol can be taken while the previous result waits on m_tready.
// Each symbol is handled by a sequencer around three single-port-read RAMs
// (transitions, lengths, suffix links); the block is busy meanwhile.
// Steps per symbol: clear the new state's transition row, read and write its
// length, walk the suffix links, check the target state's length, and when a
// clone is made copy its row (read then write per symbol), copy its link,
// redirect transitions along the walk, then point the links of the new state
// and of the target state at the clone.
// Once the table holds MAX_STATES-2 states, symbols are dropped with overflow.
// Reset: synchronous; afterwards a pass clears the root's row, with s_tready low.
// If the receiver stalls, the finished result waits in the
// output register and the next symbol's work stops at its end until the
// register is free.
module suffix_automaton_builder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [4:0] symbol, rest zero
  input  logic [sab_pkg::IN_W-1:0]   s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [10:0] new_state, [21:11] new_length, [32:22] new_link, [33] cloned,
  // [44:34] clone_state, [55:45] state_count, [56] overflow, rest zero
  output logic [sab_pkg::OUT_W-1:0]  m_tdata
);
  import sab_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_ROWCLR, S_LENRD, S_LENWR, S_WALK_RD, S_WALK_CHK,
    S_RDLP, S_RDLQ, S_CMP, S_CPRD, S_CPWR, S_CLINK, S_CLINKW,
    S_RED_RD, S_RED_CHK, S_FIN1, S_FIN2, S_DONE
  } state_t;

  localparam logic [SYM_W-1:0] K_LAST = SYM_W'(ALPHABET_SIZE - 1);

  state_t           st;
  logic [SYM_W-1:0] k, sym;
  logic [SW-1:0]    p, q, cur, clone, used, last, lp, cur_len, cur_link;
  logic             cloned, ovf;

  // RAM ports
  logic            t_we, len_we, lnk_we;
  logic [TA_W-1:0] t_waddr, t_raddr;
  logic [SW-1:0]   t_wdata, t_rdata;
  logic [SW-1:0]   len_waddr, len_wdata, len_raddr, len_rdata;
  logic [SW-1:0]   lnk_waddr, lnk_wdata, lnk_raddr, lnk_rdata;
  logic [SW-1:0]   used_inc;

  assign used_inc = used + SW'(1);
  assign s_tready = (st == S_IDLE);

  sab_ram #(.DEPTH(TRANS_DEPTH), .WIDTH(SW)) u_trans (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  sab_ram #(.DEPTH(MAX_STATES), .WIDTH(SW)) u_len (
    .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
    .raddr(len_raddr), .rdata(len_rdata)
  );

  sab_ram #(.DEPTH(MAX_STATES), .WIDTH(SW)) u_link (
    .clk(clk), .we(lnk_we), .waddr(lnk_waddr), .wdata(lnk_wdata),
    .raddr(lnk_raddr), .rdata(lnk_rdata)
  );

  // RAM address and write control per sequencer step
  always_comb begin
    t_we      = 1'b0;
    t_waddr   = trans_addr(cur, k);
    t_wdata   = '0;
    t_raddr   = trans_addr(p, sym);
    len_we    = 1'b0;
    len_waddr = cur;
    len_wdata = '0;
    len_raddr = p;
    lnk_we    = 1'b0;
    lnk_waddr = cur;
    lnk_wdata = '0;
    lnk_raddr = p;
    unique case (st)
      S_INIT: begin
        t_we    = 1'b1;
        t_waddr = trans_addr(ROOT, k);
        if (k == '0) begin
          len_we    = 1'b1;
          len_waddr = ROOT;
          lnk_we    = 1'b1;
          lnk_waddr = ROOT;
        end
      end
      S_ROWCLR: t_we = 1'b1;
      S_LENWR: begin
        len_we    = 1'b1;
        len_wdata = len_rdata + SW'(1);
      end
      S_WALK_RD: begin
        if (p == '0) begin
          lnk_we    = 1'b1;
          lnk_wdata = ROOT;
        end
      end
      S_WALK_CHK: begin
        if (t_rdata == '0) begin
          t_we    = 1'b1;
          t_waddr = trans_addr(p, sym);
          t_wdata = cur;
        end
      end
      S_RDLQ: len_raddr = q;
      S_CMP: begin
        if (len_rdata == lp + SW'(1)) begin
          lnk_we    = 1'b1;
          lnk_wdata = q;
        end else begin
          len_we    = 1'b1;
          len_waddr = used_inc;
          len_wdata = lp + SW'(1);
        end
      end
      S_CPRD: t_raddr = trans_addr(q, k);
      S_CPWR: begin
        t_we    = 1'b1;
        t_waddr = trans_addr(clone, k);
        t_wdata = t_rdata;
      end
      S_CLINK: lnk_raddr = q;
      S_CLINKW: begin
        lnk_we    = 1'b1;
        lnk_waddr = clone;
        lnk_wdata = lnk_rdata;
      end
      S_RED_CHK: begin
        if (t_rdata == q) begin
          t_we    = 1'b1;
          t_waddr = trans_addr(p, sym);
          t_wdata = clone;
        end
      end
      S_FIN1: begin
        lnk_we    = 1'b1;
        lnk_wdata = clone;
      end
      S_FIN2: begin
        lnk_we    = 1'b1;
        lnk_waddr = q;
        lnk_wdata = clone;
      end
      default: ;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_INIT;
      k        <= '0;
      used     <= ROOT;
      last     <= ROOT;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (st)
        S_INIT: begin
          k <= k + SYM_W'(1);
          if (k == K_LAST) begin
            k  <= '0;
            st <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            sym      <= s_tdata[SYM_W-1:0];
            cur      <= '0;
            cur_len  <= '0;
            cur_link <= '0;
            cloned   <= 1'b0;
            clone    <= '0;
            ovf      <= 1'b0;
            k        <= '0;
            if (s_tdata[SYM_W-1:0] >= SYM_W'(ALPHABET_SIZE)) begin
              st <= S_DONE;
            end else if (used >= SW'(MAX_STATES - 2)) begin
              ovf <= 1'b1;
              st  <= S_DONE;
            end else begin
              cur  <= used_inc;
              used <= used_inc;
              p    <= last;
              st   <= S_ROWCLR;
            end
          end
        end
        S_ROWCLR: begin
          k <= k + SYM_W'(1);
          if (k == K_LAST) begin
            k  <= '0;
            st <= S_LENRD;
          end
        end
        S_LENRD: st <= S_LENWR;
        S_LENWR: begin
          cur_len <= len_rdata + SW'(1);
          st      <= S_WALK_RD;
        end
        S_WALK_RD: begin
          if (p == '0) begin
            cur_link <= ROOT;
            st       <= S_DONE;
          end else begin
            st <= S_WALK_CHK;
          end
        end
        S_WALK_CHK: begin
          if (t_rdata == '0) begin
            p  <= lnk_rdata;
            st <= S_WALK_RD;
          end else begin
            q  <= t_rdata;
            st <= S_RDLP;
          end
        end
        S_RDLP: st <= S_RDLQ;
        S_RDLQ: begin
          lp <= len_rdata;
          st <= S_CMP;
        end
        S_CMP: begin
          if (len_rdata == lp + SW'(1)) begin
            cur_link <= q;
            st       <= S_DONE;
          end else begin
            clone  <= used_inc;
            used   <= used_inc;
            cloned <= 1'b1;
            k      <= '0;
            st     <= S_CPRD;
          end
        end
        S_CPRD: st <= S_CPWR;
        S_CPWR: begin
          k  <= k + SYM_W'(1);
          st <= S_CPRD;
          if (k == K_LAST) begin
            k  <= '0;
            st <= S_CLINK;
          end
        end
        S_CLINK:  st <= S_CLINKW;
        S_CLINKW: st <= S_RED_RD;
        S_RED_RD: st <= (p == '0) ? S_FIN1 : S_RED_CHK;
        S_RED_CHK: begin
          if (t_rdata == q) begin
            p  <= lnk_rdata;
            st <= S_RED_RD;
          end else begin
            st <= S_FIN1;
          end
        end
        S_FIN1: begin
          cur_link <= clone;
          st       <= S_FIN2;
        end
        S_FIN2: st <= S_DONE;
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {(OUT_W - RES_W)'(0), ovf, used, clone, cloned,
                         cur_link, cur_len, cur};
            m_tvalid <= 1'b1;
            if (cur != '0) begin
              last <= cur;
            end
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // State count never shrinks between resets
  a_used_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> used >= $past(used))
    else $error("state count decreased");

  // Capacity is never exceeded
  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    used <= SW'(MAX_STATES - 1))
    else $error("state count beyond capacity");

  // A clone is always the state right after the new state
  a_clone_idx: assert property (@(posedge clk) disable iff (rst)
    (st == S_DONE && cloned) |-> clone == cur + SW'(1))
    else $error("clone index mismatch");

  // Overflow results carry no new state
  a_ovf_empty: assert property (@(posedge clk) disable iff (rst)
    (st == S_DONE && ovf) |-> (cur == '0 && !cloned))
    else $error("overflow with new state");

endmodule
